>>> rtl/assert_macros.svh
// Assertion macros for RTL that checks its own logic.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/pfci_pkg.sv
// Package for the parallel flash command interface: constants, command codes,
// state types and the ID byte lookup. No dependencies.
`timescale 1ns / 1ps

package pfci_pkg;

    localparam int ADDR_BITS_DEF   = 17;
    localparam int SECTOR_BITS_DEF = 12;
    localparam int PORT_ADDR_W     = 17;
    localparam int DATA_W          = 8;
    localparam int LOW_W           = 16;

    localparam logic [LOW_W-1:0]  UNLOCK_ADDR1     = 16'h5555;
    localparam logic [LOW_W-1:0]  UNLOCK_ADDR2     = 16'h2aaa;
    localparam logic [LOW_W-1:0]  ID_MAKER_ADDR    = 16'h0000;
    localparam logic [LOW_W-1:0]  ID_DEVICE_ADDR   = 16'h0001;
    localparam logic [DATA_W-1:0] UNLOCK_DATA1     = 8'haa;
    localparam logic [DATA_W-1:0] UNLOCK_DATA2     = 8'h55;
    localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
    localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
    localparam logic [DATA_W-1:0] CMD_ERASE_ARM    = 8'h80;
    localparam logic [DATA_W-1:0] CMD_ID_ON        = 8'h90;
    localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'ha0;
    localparam logic [DATA_W-1:0] CMD_ID_OFF       = 8'hf0;
    localparam logic [DATA_W-1:0] ID_MAKER         = 8'hbf;
    localparam logic [DATA_W-1:0] ID_DEVICE        = 8'hb5;
    localparam logic [DATA_W-1:0] BYTE_ERASED      = 8'hff;
    localparam logic [DATA_W-1:0] BYTE_ZERO        = 8'h00;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_AA,
        STEP_55,
        STEP_PROG
    } cmd_step_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } fsm_state_t;

    typedef struct packed {
        cmd_step_t step;
        logic      id_mode;
        logic      armed;
    } cmd_state_t;

    typedef struct packed {
        cmd_state_t nxt;
        logic       prog_we;
        logic       sector_erase;
        logic       chip_erase;
    } cmd_dec_t;

    function automatic logic [DATA_W-1:0] id_byte(input logic [LOW_W-1:0] low16);
        logic [DATA_W-1:0] res;
        begin
            if (low16 == ID_MAKER_ADDR)
            begin
                res = ID_MAKER;
            end
            else if (low16 == ID_DEVICE_ADDR)
            begin
                res = ID_DEVICE;
            end
            else
            begin
                res = BYTE_ERASED;
            end
            return res;
        end
    endfunction

endpackage

>>> rtl/pfci_in_if.sv
// Request channel: one bus access per item (read or write).
// Depends on pfci_pkg.
`timescale 1ns / 1ps

interface pfci_in_if
    import pfci_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [PORT_ADDR_W-1:0] address;
    logic [DATA_W-1:0]      write_data;

    modport source (output valid, output action, output address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input address, input write_data,
                    output ready);
endinterface

>>> rtl/pfci_out_if.sv
// Response channel: one result item per access.
// Depends on pfci_pkg.
`timescale 1ns / 1ps

interface pfci_out_if
    import pfci_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              in_id_mode;

    modport source (output valid, output read_data, output in_id_mode, input ready);
    modport sink   (input valid, input read_data, input in_id_mode, output ready);
endinterface

>>> rtl/parallel_flash_command_interface.sv
// A read passes the registered port of the array RAM, then the output register; a
// write loads the output register as it is accepted (later while it is still held).
// Writes are taken one per cycle while the output register is free; a read holds off
// the next request until its data is loaded. Sector erase stalls input while the
// sector is swept, chip erase while the whole array is. Reset: control clears at once,
// then the array is swept to 0xFF with the request channel not ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module parallel_flash_command_interface
    import pfci_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pfci_in_if.sink     req,
    pfci_out_if.source  rsp
);
    fsm_state_t state_reg;
    fsm_state_t state_next;
    cmd_state_t cmd_reg;
    cmd_dec_t   dec;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic                 out_id_reg;
    logic [DATA_W-1:0]    res_data_reg;
    logic [DATA_W-1:0]    res_data_next;
    logic                 sweep_pend_reg;

    logic [ADDR_BITS-1:0] in_addr;
    logic                 accept;
    logic                 slot_free;
    logic                 erase_start;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [DATA_W-1:0]    ram_wdata;
    logic [DATA_W-1:0]    ram_rdata;
    logic                 out_load;
    logic [DATA_W-1:0]    out_data_d;
    logic                 out_id_d;
    logic [DATA_W-1:0]    rd_val;
    logic                 sweep_start;
    logic                 sweep_adv;
    logic [ADDR_BITS-1:0] sweep_addr;
    logic                 sweep_last;

    assign in_addr     = ADDR_BITS'(req.address);
    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign slot_free   = !out_valid_reg || rsp.ready;
    assign erase_start = dec.sector_erase || dec.chip_erase;
    assign rd_val      = cmd_reg.id_mode ? res_data_reg : ram_rdata;

    pfci_cmd u_cmd (
        .cur   (cmd_reg),
        .low16 (in_addr[LOW_W-1:0]),
        .wdata (req.write_data),
        .dec   (dec)
    );

    pfci_sweep #(
        .ADDR_BITS   (ADDR_BITS),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_sweep (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (sweep_start),
        .start_chip (dec.chip_erase),
        .base       (in_addr),
        .advance    (sweep_adv),
        .addr       (sweep_addr),
        .last       (sweep_last)
    );

    pfci_ram #(
        .WIDTH (DATA_W),
        .DEPTH (1 << ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!req.action)
                    begin
                        state_next = ST_READ;
                    end
                    else if (!slot_free)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (erase_start)
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_READ:
            begin
                state_next = slot_free ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = sweep_pend_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we        = 1'b0;
        ram_addr      = in_addr;
        ram_wdata     = req.write_data;
        out_load      = 1'b0;
        out_data_d    = res_data_reg;
        out_id_d      = cmd_reg.id_mode;
        res_data_next = res_data_reg;
        sweep_start   = 1'b0;
        sweep_adv     = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_addr  = sweep_addr;
                ram_wdata = BYTE_ERASED;
                sweep_adv = 1'b1;
            end
            ST_IDLE:
            begin
                if (accept && req.action)
                begin
                    ram_we        = dec.prog_we;
                    sweep_start   = erase_start;
                    out_load      = slot_free;
                    out_data_d    = BYTE_ZERO;
                    out_id_d      = dec.nxt.id_mode;
                    res_data_next = BYTE_ZERO;
                end
                else if (accept)
                begin
                    res_data_next = id_byte(in_addr[LOW_W-1:0]);
                end
            end
            ST_READ:
            begin
                out_load      = slot_free;
                out_data_d    = rd_val;
                res_data_next = rd_val;
            end
            ST_EMIT:
            begin
                out_load = slot_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            cmd_reg        <= '{step: STEP_IDLE, id_mode: 1'b0, armed: 1'b0};
            out_valid_reg  <= 1'b0;
            sweep_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                sweep_pend_reg <= req.action && erase_start;
            end
            if (accept && req.action)
            begin
                cmd_reg <= dec.nxt;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        if (out_load)
        begin
            out_data_reg <= out_data_d;
            out_id_reg   <= out_id_d;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.in_id_mode = out_id_reg;

    `ASSERT_NEXT(a_accept_progress, accept,
        out_valid_reg || state_reg == ST_READ || state_reg == ST_EMIT)
    `ASSERT_ALWAYS(a_prog_only_pending,
        !(state_reg == ST_IDLE && ram_we) || cmd_reg.step == STEP_PROG)
    `ASSERT_NEXT(a_erase_disarms, sweep_start, !cmd_reg.armed)
endmodule

>>> rtl/pfci_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/pfci_cmd.sv
// Command sequencer decode: unlock steps, erase arm and erase, ID mode and program.
// Depends on pfci_pkg.
`timescale 1ns / 1ps

module pfci_cmd
    import pfci_pkg::*;
(
    input  cmd_state_t        cur,
    input  logic [LOW_W-1:0]  low16,
    input  logic [DATA_W-1:0] wdata,
    output cmd_dec_t          dec
);
    always_comb
    begin
        dec              = '0;
        dec.nxt          = cur;
        case (cur.step)
            STEP_IDLE:
            begin
                if (wdata == CMD_ID_OFF)
                begin
                    dec.nxt.id_mode = 1'b0;
                end
                else if (low16 == UNLOCK_ADDR1 && wdata == UNLOCK_DATA1)
                begin
                    dec.nxt.step = STEP_AA;
                end
                else
                begin
                    dec.nxt.step = STEP_IDLE;
                end
            end
            STEP_AA:
            begin
                if (low16 == UNLOCK_ADDR2 && wdata == UNLOCK_DATA2)
                begin
                    dec.nxt.step = STEP_55;
                end
                else
                begin
                    dec.nxt.step = STEP_IDLE;
                end
            end
            STEP_55:
            begin
                dec.nxt.step = STEP_IDLE;
                if (low16 == UNLOCK_ADDR1)
                begin
                    dec.nxt.armed = 1'b0;
                    case (wdata)
                        CMD_CHIP_ERASE:
                        begin
                            dec.chip_erase = cur.armed;
                        end
                        CMD_ERASE_ARM:
                        begin
                            dec.nxt.armed = 1'b1;
                        end
                        CMD_ID_ON:
                        begin
                            dec.nxt.id_mode = 1'b1;
                        end
                        CMD_PROGRAM:
                        begin
                            dec.nxt.step = STEP_PROG;
                        end
                        CMD_ID_OFF:
                        begin
                            dec.nxt.id_mode = 1'b0;
                        end
                        default:
                        begin
                            dec.nxt.armed = 1'b0;
                        end
                    endcase
                end
                else if (wdata == CMD_SECTOR_ERASE && cur.armed)
                begin
                    dec.sector_erase = 1'b1;
                    dec.nxt.armed    = 1'b0;
                end
            end
            STEP_PROG:
            begin
                dec.prog_we  = 1'b1;
                dec.nxt.step = STEP_IDLE;
            end
            default:
            begin
                dec.nxt.step = STEP_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/pfci_sweep.sv
// Erase address walker: steps one byte per cycle while advance is high, over a sector or the whole array.
// Depends on pfci_pkg.
`timescale 1ns / 1ps

module pfci_sweep
    import pfci_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 start_chip,
    input  logic [ADDR_BITS-1:0] base,
    input  logic                 advance,
    output logic [ADDR_BITS-1:0] addr,
    output logic                 last
);
    localparam logic [ADDR_BITS-1:0] LOW_MASK =
        ADDR_BITS'((64'd1 << SECTOR_BITS) - 64'd1);

    logic [ADDR_BITS-1:0] cnt_reg;
    logic [ADDR_BITS-1:0] cnt_next;
    logic                 chip_reg;
    logic                 chip_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        chip_next = chip_reg;
        if (start)
        begin
            cnt_next  = start_chip ? '0 : (base & ~LOW_MASK);
            chip_next = start_chip;
        end
        else if (advance)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            chip_reg <= 1'b1;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            chip_reg <= chip_next;
        end
    end

    assign addr = cnt_reg;
    assign last = chip_reg ? (&cnt_reg) : ((cnt_reg & LOW_MASK) == LOW_MASK);
endmodule

>>> tb/sv/parallel_flash_command_interface_test.sv
// Testbench for parallel_flash_command_interface: drives random and directed bus accesses and
// checks each response against a shadow copy of the flash array and the command sequencer.
// Depends on pfci_pkg, pfci_in_if, pfci_out_if and the RTL of the block.
`timescale 1ns / 1ps

module parallel_flash_command_interface_test
    import pfci_pkg::*;
;
    localparam int FLASH_ADDR_BITS   = ADDR_BITS_DEF;
    localparam int FLASH_SECTOR_BITS = SECTOR_BITS_DEF;
    localparam int ARRAY_BYTES       = 1 << FLASH_ADDR_BITS;
    localparam int SECTOR_BYTES      = 1 << FLASH_SECTOR_BITS;
    localparam bit ACT_READ          = 1'b0;
    localparam bit ACT_WRITE         = 1'b1;
    localparam int PHASE_ITEMS       = 650;
    localparam longint WATCHDOG_NS   = 40_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              in_id_mode;
    } access_result_t;

    class flash_shadow;
        cmd_step_t         step;
        bit                id_mode;
        bit                armed;
        logic [DATA_W-1:0] image [0:ARRAY_BYTES-1];
        access_result_t    expected_results [$];
        int                results_checked;

        function new();
            step = STEP_IDLE;
            id_mode = 1'b0;
            armed = 1'b0;
            results_checked = 0;
            foreach (image[i])
            begin
                image[i] = BYTE_ERASED;
            end
        endfunction

        function void run_command(logic [DATA_W-1:0] cmd);
            step = STEP_IDLE;
            case (cmd)
                CMD_CHIP_ERASE:
                begin
                    if (armed)
                    begin
                        foreach (image[i])
                        begin
                            image[i] = BYTE_ERASED;
                        end
                    end
                    armed = 1'b0;
                end
                CMD_ERASE_ARM:
                begin
                    armed = 1'b1;
                end
                CMD_ID_ON:
                begin
                    id_mode = 1'b1;
                    armed = 1'b0;
                end
                CMD_PROGRAM:
                begin
                    step = STEP_PROG;
                    armed = 1'b0;
                end
                CMD_ID_OFF:
                begin
                    id_mode = 1'b0;
                    armed = 1'b0;
                end
                default:
                begin
                    armed = 1'b0;
                end
            endcase
        endfunction

        function void note_access(bit act, logic [PORT_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            logic [LOW_W-1:0] low;
            access_result_t   res;
            int               base;
            low = addr[LOW_W-1:0];
            res.read_data = BYTE_ZERO;
            if (act == ACT_WRITE)
            begin
                case (step)
                    STEP_IDLE:
                    begin
                        if (data == CMD_ID_OFF)
                        begin
                            id_mode = 1'b0;
                        end
                        else if (low == UNLOCK_ADDR1 && data == UNLOCK_DATA1)
                        begin
                            step = STEP_AA;
                        end
                    end
                    STEP_AA:
                    begin
                        step = (low == UNLOCK_ADDR2 && data == UNLOCK_DATA2) ? STEP_55 : STEP_IDLE;
                    end
                    STEP_55:
                    begin
                        if (low == UNLOCK_ADDR1)
                        begin
                            run_command(data);
                        end
                        else if (data == CMD_SECTOR_ERASE && armed)
                        begin
                            base = int'(addr) & ~(SECTOR_BYTES - 1);
                            for (int i = 0; i < SECTOR_BYTES; i++)
                            begin
                                image[base + i] = BYTE_ERASED;
                            end
                            armed = 1'b0;
                            step = STEP_IDLE;
                        end
                        else
                        begin
                            step = STEP_IDLE;
                        end
                    end
                    default:
                    begin
                        image[addr] = data;
                        step = STEP_IDLE;
                    end
                endcase
            end
            else if (id_mode)
            begin
                if (low == ID_MAKER_ADDR)
                begin
                    res.read_data = ID_MAKER;
                end
                else if (low == ID_DEVICE_ADDR)
                begin
                    res.read_data = ID_DEVICE;
                end
                else
                begin
                    res.read_data = BYTE_ERASED;
                end
            end
            else
            begin
                res.read_data = image[addr];
            end
            res.in_id_mode = id_mode;
            expected_results.push_back(res);
        endfunction

        function string check_response(logic [DATA_W-1:0] rd, logic idm);
            access_result_t exp;
            string          msg;
            msg = "";
            results_checked++;
            if (expected_results.size() == 0)
            begin
                return $sformatf(" result %0d with none pending: read_data %02h in_id_mode %0b",
                                 results_checked, rd, idm);
            end
            exp = expected_results.pop_front();
            if (rd !== exp.read_data)
            begin
                msg = {msg, $sformatf(" read_data got %02h want %02h", rd, exp.read_data)};
            end
            if (idm !== exp.in_id_mode)
            begin
                msg = {msg, $sformatf(" in_id_mode got %0b want %0b", idm, exp.in_id_mode)};
            end
            if (msg.len() != 0)
            begin
                msg = {$sformatf(" result %0d:", results_checked), msg};
            end
            return msg;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   tx_valid = 1'b0;
    logic                   tx_action = 1'b0;
    logic [PORT_ADDR_W-1:0] tx_address = '0;
    logic [DATA_W-1:0]      tx_data = '0;
    logic                   rx_ready = 1'b0;

    int          tx_idle_pct = 31;
    int          rx_idle_pct = 86;
    int          items_sent = 0;
    int          mismatches = 0;
    int          chip_erase_left = 3;
    int          sector_erase_left = 60;
    flash_shadow shadow;

    pfci_in_if  req ();
    pfci_out_if rsp ();

    assign req.valid      = tx_valid;
    assign req.action     = tx_action;
    assign req.address    = tx_address;
    assign req.write_data = tx_data;
    assign rsp.ready      = rx_ready;

    parallel_flash_command_interface #(
        .ADDR_BITS   (FLASH_ADDR_BITS),
        .SECTOR_BITS (FLASH_SECTOR_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string why);
        mismatches++;
        $display("mismatch%s", why);
    endtask

    always @(posedge clk)
    begin : response_monitor
        string why;
        if (rst_n && rsp.valid && rx_ready)
        begin
            why = shadow.check_response(rsp.read_data, rsp.in_id_mode);
            if (why.len() != 0)
            begin
                report_mismatch(why);
            end
        end
        rx_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Called at a rising edge; returns at the edge where the item is accepted, valid still high.
    task automatic drive_access(bit act, logic [PORT_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            tx_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        tx_valid   <= 1'b1;
        tx_action  <= act;
        tx_address <= addr;
        tx_data    <= data;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        shadow.note_access(act, addr, data);
        items_sent++;
    endtask

    task automatic write_byte(logic [PORT_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        drive_access(ACT_WRITE, addr, data);
    endtask

    task automatic read_byte(logic [PORT_ADDR_W-1:0] addr);
        drive_access(ACT_READ, addr, DATA_W'($urandom_range(0, 255)));
    endtask

    // Hold the number of erases bounded so the run length stays predictable.
    task automatic write_command(logic [PORT_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] cmd;
        cmd = data;
        if (cmd == CMD_CHIP_ERASE && addr[LOW_W-1:0] == UNLOCK_ADDR1)
        begin
            if (chip_erase_left == 0)
            begin
                cmd = CMD_ID_OFF;
            end
            else
            begin
                chip_erase_left--;
            end
        end
        if (cmd == CMD_SECTOR_ERASE && addr[LOW_W-1:0] != UNLOCK_ADDR1)
        begin
            if (sector_erase_left == 0)
            begin
                cmd = CMD_ERASE_ARM;
            end
            else
            begin
                sector_erase_left--;
            end
        end
        write_byte(addr, cmd);
    endtask

    function automatic logic [PORT_ADDR_W-1:0] alias_address(logic [LOW_W-1:0] low);
        return {1'($urandom_range(0, 1)), low};
    endfunction

    function automatic logic [PORT_ADDR_W-1:0] pick_address();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            return PORT_ADDR_W'($urandom_range(0, 15));
        end
        else if (sel < 5)
        begin
            return PORT_ADDR_W'(ARRAY_BYTES - 16 + $urandom_range(0, 15));
        end
        else if (sel < 6)
        begin
            return alias_address($urandom_range(0, 1) ? UNLOCK_ADDR1 : UNLOCK_ADDR2);
        end
        return PORT_ADDR_W'($urandom_range(0, ARRAY_BYTES - 1));
    endfunction

    task automatic unlock_command(logic [DATA_W-1:0] cmd);
        write_byte(alias_address(UNLOCK_ADDR1), UNLOCK_DATA1);
        write_byte(alias_address(UNLOCK_ADDR2), UNLOCK_DATA2);
        write_command(alias_address(UNLOCK_ADDR1), cmd);
    endtask

    task automatic run_directed();
        read_byte('0);
        write_byte('1, CMD_ID_OFF);
        write_byte(17'h15555, UNLOCK_DATA1);
        write_byte(17'h12aaa, UNLOCK_DATA2);
        write_byte(17'h05555, CMD_PROGRAM);
        write_byte('1, 8'h00);
        unlock_command(CMD_CHIP_ERASE);
        read_byte('1);
        unlock_command(CMD_ID_ON);
        read_byte(17'h10000);
        read_byte(17'h00001);
        read_byte(17'h0ffff);
        write_byte('0, CMD_ID_OFF);
        unlock_command(CMD_ERASE_ARM);
        write_byte(17'h05555, UNLOCK_DATA1);
        write_byte(17'h02aaa, UNLOCK_DATA2);
        write_command(17'h1f123, CMD_SECTOR_ERASE);
        read_byte('1);
        unlock_command(8'hff);
    endtask

    task automatic run_random_sequence();
        int                     kind;
        int                     n;
        logic [PORT_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]      data;
        kind = $urandom_range(0, 99);
        addr = pick_address();
        data = DATA_W'($urandom_range(0, 255));
        if (kind < 30)
        begin
            unlock_command(CMD_PROGRAM);
            if ($urandom_range(0, 3) == 0)
            begin
                read_byte(pick_address());
            end
            write_byte(addr, data);
            read_byte(addr);
        end
        else if (kind < 48)
        begin
            n = $urandom_range(1, 4);
            repeat (n) read_byte(pick_address());
        end
        else if (kind < 58)
        begin
            write_byte(addr, data);
        end
        else if (kind < 68)
        begin
            write_byte(alias_address(UNLOCK_ADDR1), UNLOCK_DATA1);
            if ($urandom_range(0, 1))
            begin
                write_byte(alias_address(UNLOCK_ADDR2), UNLOCK_DATA2);
                if ($urandom_range(0, 1))
                begin
                    read_byte(pick_address());
                end
            end
            write_command(addr, data);
        end
        else if (kind < 78)
        begin
            unlock_command(CMD_ID_ON);
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                if ($urandom_range(0, 1))
                begin
                    read_byte({1'($urandom_range(0, 1)), 15'h0, 1'($urandom_range(0, 1))});
                end
                else
                begin
                    read_byte(pick_address());
                end
            end
            n = $urandom_range(0, 3);
            if (n == 0)
            begin
                write_byte(pick_address(), CMD_ID_OFF);
            end
            else if (n == 1)
            begin
                unlock_command(CMD_ID_OFF);
            end
        end
        else if (kind < 86)
        begin
            unlock_command(CMD_ERASE_ARM);
            unlock_command(data);
            read_byte(addr);
        end
        else if (kind < 94)
        begin
            unlock_command(CMD_ERASE_ARM);
            write_byte(alias_address(UNLOCK_ADDR1), UNLOCK_DATA1);
            write_byte(alias_address(UNLOCK_ADDR2), UNLOCK_DATA2);
            if ($urandom_range(0, 4) == 0)
            begin
                addr = alias_address(UNLOCK_ADDR1);
            end
            write_command(addr, CMD_SECTOR_ERASE);
            read_byte(addr);
            read_byte(addr ^ PORT_ADDR_W'($urandom_range(0, SECTOR_BYTES - 1)));
        end
        else if (kind < 97)
        begin
            write_byte(alias_address(UNLOCK_ADDR1), UNLOCK_DATA1);
            write_byte(alias_address(UNLOCK_ADDR2), UNLOCK_DATA2);
            write_command(addr, CMD_SECTOR_ERASE);
            read_byte(addr);
        end
        else
        begin
            unlock_command(CMD_ERASE_ARM);
            unlock_command(CMD_CHIP_ERASE);
            read_byte(addr);
        end
    endtask

    initial
    begin
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        shadow = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (items_sent < PHASE_ITEMS)
        begin
            run_random_sequence();
        end
        tx_idle_pct = 86;
        rx_idle_pct = 31;
        while (items_sent < 2 * PHASE_ITEMS)
        begin
            run_random_sequence();
        end
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (items_sent < 3 * PHASE_ITEMS)
        begin
            run_random_sequence();
        end
        tx_valid <= 1'b0;
        while (shadow.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
